### src/ultrasonic_echo_ranger_macros.svh
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Shared concurrent-assertion shorthands, clocked on clk with rst_n low
// disabling the check.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// Same-cycle implication
`define UER_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/uer_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Widths, register indexes, status codes and the result record.
// ----------------------------------------------------------------------------
package uer_pkg;

    // Counter width for phase, echo width and guard counters
    localparam int CNT_W = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration register widths
    localparam int TRIG_W  = 10;
    localparam int TOUT_W  = 17;
    localparam int GUARD_W = 17;
    localparam int CFG_W   = 17;
    localparam int RANGE_W = 15;

    typedef logic [1:0]         cfg_idx_t;
    typedef logic [CFG_W-1:0]   cfg_data_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [1:0]         status_t;
    typedef logic [RANGE_W-1:0] range_t;

    // Register indexes
    localparam cfg_idx_t REG_TRIGGER_TICKS = 2'd0;
    localparam cfg_idx_t REG_TIMEOUT_TICKS = 2'd1;
    localparam cfg_idx_t REG_GUARD_TICKS   = 2'd2;

    // Status codes
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_BUSY    = 2'd1;
    localparam status_t ST_TIMEOUT = 2'd2;

    // range = floor(w * 340 / 2 / 1000) = floor(17 * w / 100), done as
    // 17 * w * ceil(2^29 / 100) >> 29, exact while 17 * w stays below 6.1e6
    localparam int RANGE_MUL_W = 27;
    localparam logic [RANGE_MUL_W-1:0] RANGE_MUL = 27'd91268070;
    localparam int RANGE_SHIFT = 29;
    localparam range_t RANGE_MAX = {RANGE_W{1'b1}};

    typedef struct packed {
        logic    trigger_level;
        logic    done_res;
        status_t status;
        range_t  distance_mm;
    } res_t;

endpackage

### src/uer_if.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger channels
// Valid/ready channels for the per-tick input and the per-tick result.
// ----------------------------------------------------------------------------
interface uer_in_if;
    logic valid;
    logic ready;
    logic start_request;
    logic echo_level;

    modport source (output valid, output start_request, output echo_level, input ready);
    modport sink   (input valid, input start_request, input echo_level, output ready);
endinterface

interface uer_out_if;
    logic        valid;
    logic        ready;
    logic        trigger_level;
    logic        done_res;
    logic [1:0]  status;
    logic [14:0] distance_mm;

    modport source (output valid, output trigger_level, output done_res, output status,
                    output distance_mm, input ready);
    modport sink   (input valid, input trigger_level, input done_res, input status,
                    input distance_mm, output ready);
endinterface

### src/ultrasonic_echo_ranger.sv
// Each tick's result is registered on its transfer, into the output register
// or the skid entry; one tick per cycle is taken while the skid is empty.
// State update and range multiply lie between state and result registers.
// A two-entry result buffer (output register plus skid) keeps input open
// while one result waits. Reset clears the phase to idle, all counters to
// zero, the guard counter to saturated, and loads the register defaults.
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Trigger pulse generation, echo width measurement, range, busy and timeout.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  uer_pkg::cfg_idx_t  cfg_index,
    input  uer_pkg::cfg_data_t cfg_data,
    uer_in_if.sink            tick,
    uer_out_if.source         result
);
    import uer_pkg::*;

`include "ultrasonic_echo_ranger_macros.svh"

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;

    // Configuration registers
    logic [TRIG_W-1:0]  trig_ticks_reg;
    logic [TOUT_W-1:0]  tout_ticks_reg;
    logic [GUARD_W-1:0] guard_ticks_reg;

    // Measurement state
    logic [1:0] phase_reg, phase_next;
    cnt_t       phase_cnt_reg, phase_cnt_next;
    cnt_t       width_reg, width_next;
    logic       started_reg, started_next;
    cnt_t       guard_reg, guard_next;
    logic       last_echo_reg;

    // Result buffer
    logic out_valid_reg, skid_valid_reg;
    res_t out_data_reg, skid_data_reg;
    res_t res_next;

    logic in_fire, out_fire;
    logic rise, fall;
    cnt_t guard_inc, phase_inc, width_inc, tlen;
    logic guard_ok, timeout_hit;
    logic [CNT_W+RANGE_MUL_W-1:0] prod;
    logic [CNT_W+RANGE_MUL_W-RANGE_SHIFT-1:0] quot;
    range_t range_sat;

    assign in_fire    = tick.valid && tick.ready;
    assign out_fire   = result.valid && result.ready;
    assign tick.ready = !skid_valid_reg;

    assign result.valid         = out_valid_reg;
    assign result.trigger_level = out_data_reg.trigger_level;
    assign result.done_res      = out_data_reg.done_res;
    assign result.status        = out_data_reg.status;
    assign result.distance_mm   = out_data_reg.distance_mm;

    // Edge detect and saturating increments
    assign rise      = tick.echo_level && !last_echo_reg;
    assign fall      = !tick.echo_level && last_echo_reg;
    assign guard_inc = (guard_reg == CNT_MAX) ? CNT_MAX : guard_reg + 1'b1;
    assign phase_inc = (phase_cnt_reg == CNT_MAX) ? CNT_MAX : phase_cnt_reg + 1'b1;
    assign width_inc = (width_reg == CNT_MAX) ? CNT_MAX : width_reg + 1'b1;
    assign tlen      = (trig_ticks_reg == '0) ? CNT_W'(1) : CNT_W'(trig_ticks_reg);
    assign guard_ok  = (guard_inc >= CNT_W'(guard_ticks_reg)) || (guard_inc == CNT_MAX);
    assign timeout_hit = (phase_inc >= CNT_W'(tout_ticks_reg)) || (phase_inc == CNT_MAX);

    // Range from the stored width (echo is low on the falling-edge tick)
    assign prod = (CNT_W+RANGE_MUL_W)'(width_reg) * (CNT_W+RANGE_MUL_W)'(RANGE_MUL);
    assign quot = prod[CNT_W+RANGE_MUL_W-1:RANGE_SHIFT];
    assign range_sat = (48'(quot) > 48'(RANGE_MAX)) ? RANGE_MAX : RANGE_W'(quot);

    // Per-tick next state and result
    always_comb
    begin
        phase_next     = phase_reg;
        phase_cnt_next = phase_cnt_reg;
        width_next     = width_reg;
        started_next   = started_reg;
        guard_next     = guard_inc;
        res_next       = '0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (tick.start_request)
                begin
                    if (guard_ok)
                    begin
                        guard_next             = '0;
                        started_next           = 1'b0;
                        width_next             = '0;
                        res_next.trigger_level = 1'b1;
                        if (CNT_W'(1) >= tlen)
                        begin
                            phase_next     = PH_WAIT;
                            phase_cnt_next = '0;
                        end
                        else
                        begin
                            phase_next     = PH_TRIG;
                            phase_cnt_next = CNT_W'(1);
                        end
                    end
                    else
                    begin
                        res_next.done_res = 1'b1;
                        res_next.status   = ST_BUSY;
                    end
                end
            end
            PH_TRIG:
            begin
                res_next.trigger_level = 1'b1;
                phase_cnt_next         = phase_inc;
                if (phase_inc >= tlen)
                begin
                    phase_next     = PH_WAIT;
                    phase_cnt_next = '0;
                end
                if (tick.start_request)
                begin
                    res_next.done_res = 1'b1;
                    res_next.status   = ST_BUSY;
                end
            end
            default:
            begin
                // wait phase; the unused code behaves the same
                phase_cnt_next = phase_inc;
                if (started_reg)
                begin
                    if (tick.echo_level)
                        width_next = width_inc;
                end
                else if (rise)
                begin
                    started_next = 1'b1;
                    width_next   = CNT_W'(1);
                end
                if (started_reg && fall)
                begin
                    res_next.done_res    = 1'b1;
                    res_next.status      = ST_OK;
                    res_next.distance_mm = range_sat;
                    phase_next           = PH_IDLE;
                    phase_cnt_next       = '0;
                    started_next         = 1'b0;
                end
                else if (timeout_hit)
                begin
                    res_next.done_res = 1'b1;
                    res_next.status   = ST_TIMEOUT;
                    phase_next        = PH_IDLE;
                    phase_cnt_next    = '0;
                    started_next      = 1'b0;
                end
                else if (tick.start_request)
                begin
                    res_next.done_res = 1'b1;
                    res_next.status   = ST_BUSY;
                end
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_ticks_reg  <= TRIG_W'(10);
            tout_ticks_reg  <= TOUT_W'(100000);
            guard_ticks_reg <= GUARD_W'(60000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TRIGGER_TICKS: trig_ticks_reg  <= cfg_data[TRIG_W-1:0];
                REG_TIMEOUT_TICKS: tout_ticks_reg  <= cfg_data[TOUT_W-1:0];
                REG_GUARD_TICKS:   guard_ticks_reg <= cfg_data[GUARD_W-1:0];
                default:           ;
            endcase
        end
    end

    // State update on each tick transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            phase_cnt_reg <= '0;
            width_reg     <= '0;
            started_reg   <= 1'b0;
            guard_reg     <= CNT_MAX;
            last_echo_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg     <= phase_next;
            phase_cnt_reg <= phase_cnt_next;
            width_reg     <= width_next;
            started_reg   <= started_next;
            guard_reg     <= guard_next;
            last_echo_reg <= tick.echo_level;
        end
    end

    // Result buffer control: output register with a skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= 1'b0;
        end
    end

    // Result buffer payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
                out_data_reg <= res_next;
            else
                skid_data_reg <= res_next;
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    // Checks
    `UER_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid entry held while output register empty")
    `UER_ASSERT_NOW(a_timeout_only_in_wait,
        in_fire && res_next.done_res && (res_next.status == ST_TIMEOUT),
        (phase_reg != PH_IDLE) && (phase_reg != PH_TRIG),
        "timeout reported outside the wait phase")
    `UER_ASSERT_NEXT(a_start_clears_guard,
        in_fire && (phase_reg == PH_IDLE) && (phase_next != PH_IDLE),
        guard_reg == '0,
        "accepted start did not clear the guard counter")
    `UER_ASSERT_NOW(a_echo_only_in_wait, started_reg,
        (phase_reg != PH_IDLE) && (phase_reg != PH_TRIG),
        "echo marked started outside the wait phase")
    `UER_ASSERT_NOW(a_trigger_not_done_ok,
        in_fire && res_next.trigger_level,
        !(res_next.done_res && (res_next.status == ST_OK)),
        "measurement result reported while trigger high")

endmodule

### verif/ultrasonic_echo_ranger_tb.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger testbench
// Drives one echo/start tick per transfer and checks every per-tick result
// against a tick-by-tick prediction of trigger, busy, timeout and range.
// A directed opening covers defaults, zero-valued registers, masking,
// same-tick edge/timeout races, a long echo under the widest timeout and
// a start within the widest guard. Randomized measurement sequences with
// noise follow over several register settings. Ticks come in bursts
// with random gaps, and result ready stalls in changing patterns.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_tb;
    import uer_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_WAIT} ranger_phase_e;
    typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_e;

    // Index with no register behind it; writes must be ignored
    localparam cfg_idx_t REG_UNUSED = 2'd3;
    // Cycles with no transfer on either channel before the run is abandoned
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_SETTINGS = 6;
    localparam int TICKS_PER_SETTING = 120;

    // ------------------------------------------------------------------------
    // Range predictor and result checking
    // ------------------------------------------------------------------------
    class ranger_scoreboard;
        logic [TRIG_W-1:0] trig_ticks;
        cnt_t              tout_ticks;
        cnt_t              guard_ticks;
        ranger_phase_e     phase;
        cnt_t              phase_cnt;
        cnt_t              width_cnt;
        cnt_t              guard_cnt;
        logic              echo_on;
        logic              last_echo;
        res_t              readings_due[$];
        int                mismatches;
        int                n_ranges;
        int                n_busy;
        int                n_timeouts;
        int                max_range;

        function new();
            trig_ticks  = 10'd10;
            tout_ticks  = 17'd100000;
            guard_ticks = 17'd60000;
            phase       = PH_IDLE;
            phase_cnt   = '0;
            width_cnt   = '0;
            guard_cnt   = CNT_MAX;
            echo_on     = 1'b0;
            last_echo   = 1'b0;
            mismatches  = 0;
            n_ranges    = 0;
            n_busy      = 0;
            n_timeouts  = 0;
            max_range   = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, cfg_data_t data);
            case (idx)
                REG_TRIGGER_TICKS: trig_ticks  = data[TRIG_W-1:0];
                REG_TIMEOUT_TICKS: tout_ticks  = data[TOUT_W-1:0];
                REG_GUARD_TICKS:   guard_ticks = data[GUARD_W-1:0];
                default: ;
            endcase
        endfunction

        function cnt_t bump(cnt_t v);
            return (v == CNT_MAX) ? v : v + 1'b1;
        endfunction

        // One accepted tick: advance the state and queue the expected result
        function void note_tick(logic start, logic echo);
            res_t        r;
            logic        rise;
            logic        fall;
            cnt_t        tlen;
            logic [31:0] mm;
            r    = '0;
            rise = echo && !last_echo;
            fall = !echo && last_echo;
            tlen = (trig_ticks == '0) ? cnt_t'(1) : cnt_t'(trig_ticks);
            guard_cnt = bump(guard_cnt);
            case (phase)
                PH_IDLE:
                begin
                    if (start) begin
                        if (guard_cnt >= guard_ticks || guard_cnt == CNT_MAX) begin
                            guard_cnt       = '0;
                            echo_on         = 1'b0;
                            width_cnt       = '0;
                            r.trigger_level = 1'b1;
                            phase_cnt       = cnt_t'(1);
                            phase           = PH_TRIG;
                            if (phase_cnt >= tlen) begin
                                phase     = PH_WAIT;
                                phase_cnt = '0;
                            end
                        end
                        else begin
                            r.done_res = 1'b1;
                            r.status   = ST_BUSY;
                        end
                    end
                end
                PH_TRIG:
                begin
                    r.trigger_level = 1'b1;
                    phase_cnt = bump(phase_cnt);
                    if (phase_cnt >= tlen) begin
                        phase     = PH_WAIT;
                        phase_cnt = '0;
                    end
                    if (start) begin
                        r.done_res = 1'b1;
                        r.status   = ST_BUSY;
                    end
                end
                default:
                begin
                    phase_cnt = bump(phase_cnt);
                    if (echo_on) begin
                        if (echo)
                            width_cnt = bump(width_cnt);
                    end
                    else if (rise) begin
                        echo_on   = 1'b1;
                        width_cnt = cnt_t'(1);
                    end
                    // falling edge beats timeout and a stray start on the same tick
                    if (echo_on && fall) begin
                        mm = 32'(width_cnt) * 32'd340 / 32'd2 / 32'd1000;
                        r.distance_mm = (mm > 32'(RANGE_MAX)) ? RANGE_MAX : mm[RANGE_W-1:0];
                        r.done_res = 1'b1;
                        r.status   = ST_OK;
                        phase      = PH_IDLE;
                        phase_cnt  = '0;
                        echo_on    = 1'b0;
                    end
                    else if (phase_cnt >= tout_ticks || phase_cnt == CNT_MAX) begin
                        r.done_res = 1'b1;
                        r.status   = ST_TIMEOUT;
                        phase      = PH_IDLE;
                        phase_cnt  = '0;
                        echo_on    = 1'b0;
                    end
                    else if (start) begin
                        r.done_res = 1'b1;
                        r.status   = ST_BUSY;
                    end
                end
            endcase
            last_echo = echo;
            readings_due.push_back(r);
        endfunction

        function void report(string what, res_t want, res_t got);
            mismatches++;
            if (mismatches <= 10)
                $display({"MISMATCH %s: expected trig=%0b done=%0b status=%0d range=%0d,",
                          " got trig=%0b done=%0b status=%0d range=%0d"},
                         what, want.trigger_level, want.done_res, want.status,
                         want.distance_mm, got.trigger_level, got.done_res, got.status,
                         got.distance_mm);
        endfunction

        // One accepted result against the oldest expectation
        function void check_reading(res_t got);
            res_t want;
            if (readings_due.size() == 0) begin
                report("result with no tick outstanding", '0, got);
                return;
            end
            want = readings_due.pop_front();
            if (got.trigger_level !== want.trigger_level || got.done_res !== want.done_res ||
                got.status !== want.status || got.distance_mm !== want.distance_mm)
                report("result", want, got);
            if (want.done_res) begin
                case (want.status)
                    ST_OK:
                    begin
                        n_ranges++;
                        if (int'(want.distance_mm) > max_range)
                            max_range = int'(want.distance_mm);
                    end
                    ST_BUSY:    n_busy++;
                    ST_TIMEOUT: n_timeouts++;
                    default: ;
                endcase
            end
        endfunction

        function int pending();
            return readings_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    uer_in_if  tick_if();
    uer_out_if res_if();

    ranger_scoreboard sb;

    int       burst_left = 0;
    int       ticks_sent = 0;
    int       settings_used = 0;
    int       cur_trig_len = 10;
    int       cur_tout = 100000;
    int       idle_cycles = 0;
    int       rx_left = 0;
    int       rx_beat = 0;
    rx_mode_e rx_mode = RX_OPEN;

    always #5 clk = ~clk;

    ultrasonic_echo_ranger dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick      (tick_if),
        .result    (res_if)
    );

    // Result ready: the stall pattern and how long it runs are drawn at random
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_left <= $urandom_range(50, 400);
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
        end
        else begin
            rx_left <= rx_left - 1;
        end
        rx_beat <= rx_beat + 1;
        case (rx_mode)
            RX_OPEN:     res_if.ready <= 1'b1;
            RX_SPARSE:   res_if.ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: res_if.ready <= (rx_beat % 3 == 0);
            default:     res_if.ready <= ($urandom_range(0, 9) < 4);
        endcase
    end

    // Transfer monitors and stall watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (tick_if.valid && tick_if.ready)
                sb.note_tick(tick_if.start_request, tick_if.echo_level);
            if (res_if.valid && res_if.ready)
                sb.check_reading({res_if.trigger_level, res_if.done_res, res_if.status,
                                  res_if.distance_mm});
        end
        if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // One tick transfer; bursts of random length with random gaps between
    task automatic send_tick(input logic start, input logic echo);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                tick_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        tick_if.valid         <= 1'b1;
        tick_if.start_request <= start;
        tick_if.echo_level    <= echo;
        @(posedge clk);
        while (!tick_if.ready) @(posedge clk);
        ticks_sent++;
    endtask

    // Hold off ticks until every expected result has been checked
    task automatic settle();
        tick_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input cfg_data_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Rewrite all registers while the block is drained
    task automatic load_config(input cfg_data_t trig, input cfg_data_t tout,
                               input cfg_data_t guard);
        settle();
        put_reg(REG_TRIGGER_TICKS, trig);
        put_reg(REG_TIMEOUT_TICKS, tout);
        if ($urandom_range(0, 1))
            put_reg(REG_UNUSED, cfg_data_t'($urandom));
        put_reg(REG_GUARD_TICKS, guard);
        cfg_we <= 1'b0;
        cur_trig_len = (trig[TRIG_W-1:0] == '0) ? 1 : int'(trig[TRIG_W-1:0]);
        cur_tout = int'(tout);
        settings_used++;
    endtask

    function automatic logic stray(input int pct);
        return ($urandom_range(0, 99) < pct);
    endfunction

    // Start, quiet trigger and delay, echo pulse of the given width, then low
    task automatic measure(input int delay, input int high, input int noise);
        send_tick(1'b1, 1'b0);
        repeat (cur_trig_len - 1 + delay) send_tick(stray(noise), 1'b0);
        repeat (high) send_tick(stray(noise), 1'b1);
        send_tick(stray(noise), 1'b0);
    endtask

    // Let any open measurement run out before the registers change
    task automatic close_measurement();
        settle();
        while (sb.phase != PH_IDLE) send_tick(1'b0, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int base;
        int kind;
        int high;
        int cap;
        cfg_data_t trig_data;

        sb = new();
        rst_n                 = 1'b0;
        tick_if.valid         <= 1'b0;
        tick_if.start_request <= 1'b0;
        tick_if.echo_level    <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= REG_TRIGGER_TICKS;
        cfg_data              <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults: first start passes on the saturated guard counter,
        // starts during trigger and wait are busy, short pulse gives 0 mm,
        // a start dropped on the edge tick, then a start inside the guard
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        repeat (8) send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);

        // Zero trigger (high bits masked away) acts as one tick, zero timeout
        // ends on the first wait tick, zero guard allows back-to-back starts,
        // a falling edge with no rising edge before it is ignored
        load_config(17'h1FC00, '0, '0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);

        // Falling edge on the timeout tick wins, and the start there is dropped
        load_config(17'd1, 17'd5, 17'd3);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        repeat (5) send_tick(1'b0, 1'b0);

        // Widest timeout with a long echo, then a start within the widest guard
        load_config(17'd1, cfg_data_t'(CNT_MAX), '0);
        measure(5, 400, 2);
        load_config(17'd1, cfg_data_t'(CNT_MAX), cfg_data_t'(CNT_MAX));
        send_tick(1'b1, 1'b0);
        close_measurement();

        // Randomized measurements over several register settings
        for (int s = 0; s < RANDOM_SETTINGS; s++) begin
            trig_data = cfg_data_t'($urandom);
            trig_data[TRIG_W-1:0] = TRIG_W'($urandom_range(0, 16));
            load_config(trig_data, cfg_data_t'($urandom_range(1, 300)),
                        cfg_data_t'($urandom_range(0, 150)));
            base = ticks_sent;
            while (ticks_sent - base < TICKS_PER_SETTING) begin
                kind = $urandom_range(0, 9);
                if (kind <= 5) begin
                    cap = (cur_tout + 20 < 500) ? cur_tout + 20 : 500;
                    high = ($urandom_range(0, 7) == 0) ? $urandom_range(0, cap)
                                                        : $urandom_range(0, 80);
                    measure($urandom_range(0, 20), high, $urandom_range(0, 5));
                end
                else if (kind == 6) begin
                    // no echo at all
                    measure((cur_tout < 60) ? cur_tout : 60, 0, 3);
                end
                else if (kind == 7) begin
                    repeat ($urandom_range(5, 30))
                        send_tick(($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)));
                end
                else if (kind == 8) begin
                    // start followed by a glitchy echo
                    send_tick(1'b1, 1'b0);
                    repeat ($urandom_range(5, 40))
                        send_tick(stray(3), 1'($urandom_range(0, 1)));
                end
                else begin
                    // quiet stretch so the guard interval can pass
                    repeat ($urandom_range(0, 100))
                        send_tick(1'b0, 1'($urandom_range(0, 1)));
                end
            end
            close_measurement();
        end

        // Drain, then allow the result path latency to pass
        settle();
        repeat (4) @(posedge clk);

        $display("Run covered %0d ticks over %0d register settings", ticks_sent,
                 settings_used + 1);
        $display("Outcomes: %0d ranges (largest %0d mm), %0d busy, %0d timeouts, %0d mismatches",
                 sb.n_ranges, sb.max_range, sb.n_busy, sb.n_timeouts, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/uer_pkg.sv
src/uer_if.sv
src/ultrasonic_echo_ranger.sv
verif/ultrasonic_echo_ranger_tb.sv
